// ===== rtl/llsf_pkg.sv =====
// ----------------------------------------------------------------------------
// llsf_pkg
// Shared constants and types for the least-squares line fit block.
// ----------------------------------------------------------------------------
package llsf_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // serial multiplier operand and product widths
   localparam int MUL_W  = 52;
   localparam int PROD_W = 2 * MUL_W;

   // divider numerator (Q.16 slope or Q.4 intercept scaling) and denominator widths
   localparam int NUM_W = 72;
   localparam int DEN_W = 52;

   typedef struct packed {
      logic                    start;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } div_req_type;

endpackage

// ===== rtl/llsf_mul.sv =====
// ----------------------------------------------------------------------------
// llsf_mul
// Shift-add signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module llsf_mul import llsf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mul_req_type              mul_req,
   output logic                     mul_done,
   output logic signed [PROD_W-1:0] mul_prod
);

   localparam int CW = $clog2(MUL_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [MUL_W-1:0]  a_ff, a_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [MUL_W:0]    upper;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      upper   = {1'b0, acc_ff[PROD_W-1:MUL_W]};
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(MUL_W);
         neg_in  = mul_req.a[MUL_W-1] ^ mul_req.b[MUL_W-1];
         a_in    = mul_req.a[MUL_W-1] ? MUL_W'(-mul_req.a) : MUL_W'(mul_req.a);
         acc_in  = {{MUL_W{1'b0}},
                    mul_req.b[MUL_W-1] ? MUL_W'(-mul_req.b) : MUL_W'(mul_req.b)};
      end else if (busy_ff) begin
         // add the multiplicand into the high half, then shift right
         if (acc_ff[0]) begin
            upper = {1'b0, acc_ff[PROD_W-1:MUL_W]} + {1'b0, a_ff};
         end
         acc_in = {upper, acc_ff[MUL_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign mul_done = done_ff;
   assign mul_prod = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

// ===== rtl/llsf_div.sv =====
// ----------------------------------------------------------------------------
// llsf_div
// Restoring signed divider, truncating toward zero, result saturated to 32 bits.
// ----------------------------------------------------------------------------
module llsf_div import llsf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        div_req,
   output logic               div_done,
   output logic signed [31:0] div_quo
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;
   logic [NUM_W-1:0] limit;
   logic [NUM_W-1:0] qsat;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         neg_in  = div_req.num[NUM_W-1] ^ div_req.den[DEN_W-1];
         num_in  = div_req.num[NUM_W-1] ? NUM_W'(-div_req.num) : NUM_W'(div_req.num);
         den_in  = div_req.den[DEN_W-1] ? DEN_W'(-div_req.den) : DEN_W'(div_req.den);
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // clamp the magnitude, the negative side reaches one step further
   assign limit    = neg_ff ? NUM_W'(33'h0_8000_0000) : NUM_W'(33'h0_7FFF_FFFF);
   assign qsat     = (quo_ff > limit) ? limit : quo_ff;
   assign div_done = done_ff;
   assign div_quo  = neg_ff ? 32'(-qsat) : qsat[31:0];

endmodule

// ===== rtl/linear_least_squares_fit.sv =====
// Points load at one per cycle; the block takes a new point every cycle while loading.
// After the point marked last, the fit runs six products on the shared shift-add multiplier,
// two divisions and a residual pass per point (store read, product, difference, squaring);
// a singular set stops after the two determinant products.
// The result waits in an output register; loading of the next set starts meanwhile.
// Reset (synchronous, active high) clears the sums, the count and the handshake state.
// ----------------------------------------------------------------------------
// linear_least_squares_fit
// Least-squares straight-line fit with point store and residual sum.
// ----------------------------------------------------------------------------
module linear_least_squares_fit import llsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // x_value[15:0], y_value[31:16]
   input  logic         req_tlast,   // last_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // slope[31:0], intercept[63:32],
                                     // residual_sum[111:64], point_count[120:112]
   output logic         rsp_tuser    // singular
);

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_DET1  = 4'd1;
   localparam logic [3:0] S_DET2  = 4'd2;
   localparam logic [3:0] S_NS1   = 4'd3;
   localparam logic [3:0] S_NS2   = 4'd4;
   localparam logic [3:0] S_DIVS  = 4'd5;
   localparam logic [3:0] S_NI1   = 4'd6;
   localparam logic [3:0] S_NI2   = 4'd7;
   localparam logic [3:0] S_DIVI  = 4'd8;
   localparam logic [3:0] S_RREAD = 4'd9;
   localparam logic [3:0] S_RMUL  = 4'd10;
   localparam logic [3:0] S_RDIFF = 4'd11;
   localparam logic [3:0] S_RSQ   = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [3:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [23:0]      sum_x_ff, sum_x_in;
   logic signed [23:0]      sum_y_ff, sum_y_in;
   logic signed [39:0]      sum_xx_ff, sum_xx_in;
   logic signed [39:0]      sum_xy_ff, sum_xy_in;
   logic                    issued_ff, issued_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;

   logic signed [NUM_W-1:0] tmp_ff, tmp_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic signed [DEN_W-1:0] det_ff, det_in;
   logic                    sing_ff, sing_in;
   logic signed [31:0]      slope_ff, slope_in;
   logic signed [31:0]      ic_ff, ic_in;
   logic [47:0]             res_ff, res_in;
   logic signed [47:0]      sp_ff, sp_in;
   logic signed [15:0]      py_ff, py_in;
   logic signed [49:0]      r_ff, r_in;
   logic [127:0]            rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   logic [31:0]             mem [MAX_POINTS];
   logic [31:0]             rd_data_ff;

   logic                    accept;
   logic                    store_en;
   logic signed [15:0]      in_x, in_y, px, py;
   logic signed [31:0]      xx, xy;
   logic signed [NUM_W-1:0] diff;
   logic [47:0]             term;
   logic [48:0]             res_sum;
   logic signed [MUL_W-1:0] n_ext;

   mul_req_type             mul_req;
   logic                    mul_done;
   logic signed [PROD_W-1:0] mul_prod;
   div_req_type             div_req;
   logic                    div_done;
   logic signed [31:0]      div_quo;

   llsf_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_prod (mul_prod)
   );

   llsf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   assign req_tready = (state_ff == S_LOAD);
   assign accept     = req_tvalid & req_tready;
   assign store_en   = accept & (count_ff < CNT_W'(MAX_POINTS));
   assign in_x       = req_tdata[15:0];
   assign in_y       = req_tdata[31:16];
   assign xx         = in_x * in_x;
   assign xy         = in_x * in_y;
   assign px         = rd_data_ff[31:16];
   assign py         = rd_data_ff[15:0];
   assign n_ext      = {{(MUL_W-CNT_W){1'b0}}, count_ff};
   assign diff       = tmp_ff - mul_prod[NUM_W-1:0];
   assign term       = (|mul_prod[PROD_W-1:80]) ? '1 : mul_prod[79:32];
   assign res_sum    = {1'b0, res_ff} + {1'b0, term};

   // store writes at the count and the residual pass reads at the index; they never overlap
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[count_ff[ADDR_W-1:0]] <= {in_x, in_y};
      end
      rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   // operand select for the shared units
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      div_req.start = 1'b0;
      div_req.num   = num_ff;
      div_req.den   = det_ff;
      case (state_ff)
         S_DET1: begin
            mul_req.a = n_ext;
            mul_req.b = MUL_W'(sum_xx_ff);
         end
         S_DET2: begin
            mul_req.a = MUL_W'(sum_x_ff);
            mul_req.b = MUL_W'(sum_x_ff);
         end
         S_NS1: begin
            mul_req.a = n_ext;
            mul_req.b = MUL_W'(sum_xy_ff);
         end
         S_NS2: begin
            mul_req.a = MUL_W'(sum_x_ff);
            mul_req.b = MUL_W'(sum_y_ff);
         end
         S_NI1: begin
            mul_req.a = MUL_W'(sum_xx_ff);
            mul_req.b = MUL_W'(sum_y_ff);
         end
         S_NI2: begin
            mul_req.a = MUL_W'(sum_x_ff);
            mul_req.b = MUL_W'(sum_xy_ff);
         end
         S_RSQ: begin
            mul_req.a = MUL_W'(r_ff);
            mul_req.b = MUL_W'(r_ff);
         end
         default: begin
         end
      endcase
      if (!issued_ff) begin
         case (state_ff)
            S_DET1, S_DET2, S_NS1, S_NS2, S_NI1, S_NI2, S_RSQ: mul_req.start = 1'b1;
            S_DIVS, S_DIVI:                                    div_req.start = 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_xx_in    = sum_xx_ff;
      sum_xy_in    = sum_xy_ff;
      issued_in    = issued_ff | mul_req.start | div_req.start;
      idx_in       = idx_ff;
      tmp_in       = tmp_ff;
      num_in       = num_ff;
      det_in       = det_ff;
      sing_in      = sing_ff;
      slope_in     = slope_ff;
      ic_in        = ic_ff;
      res_in       = res_ff;
      sp_in        = sp_ff;
      py_in        = py_ff;
      r_in         = r_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      case (state_ff)
         S_LOAD: begin
            if (store_en) begin
               sum_x_in  = sum_x_ff + 24'(in_x);
               sum_y_in  = sum_y_ff + 24'(in_y);
               sum_xx_in = sum_xx_ff + 40'(xx);
               sum_xy_in = sum_xy_ff + 40'(xy);
               count_in  = count_ff + 1'b1;
            end
            if (accept && req_tlast) begin
               state_in = S_DET1;
            end
         end
         S_DET1, S_NS1, S_NI1: begin
            if (issued_ff && mul_done) begin
               tmp_in    = mul_prod[NUM_W-1:0];
               issued_in = 1'b0;
               state_in  = state_ff + 1'b1;
            end
         end
         S_DET2: begin
            if (issued_ff && mul_done) begin
               det_in    = diff[DEN_W-1:0];
               issued_in = 1'b0;
               if (diff == '0) begin
                  // singular set: no fit, slope, intercept and residual sum zero
                  sing_in  = 1'b1;
                  slope_in = '0;
                  ic_in    = '0;
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  sing_in  = 1'b0;
                  state_in = S_NS1;
               end
            end
         end
         S_NS2: begin
            if (issued_ff && mul_done) begin
               num_in    = diff <<< 16;
               issued_in = 1'b0;
               state_in  = S_DIVS;
            end
         end
         S_NI2: begin
            if (issued_ff && mul_done) begin
               num_in    = diff <<< 4;
               issued_in = 1'b0;
               state_in  = S_DIVI;
            end
         end
         S_DIVS: begin
            if (issued_ff && div_done) begin
               slope_in  = div_quo;
               issued_in = 1'b0;
               state_in  = S_NI1;
            end
         end
         S_DIVI: begin
            if (issued_ff && div_done) begin
               ic_in     = div_quo;
               issued_in = 1'b0;
               idx_in    = '0;
               res_in    = '0;
               state_in  = S_RREAD;
            end
         end
         S_RREAD: begin
            state_in = S_RMUL;
         end
         S_RMUL: begin
            sp_in    = slope_ff * px;
            py_in    = py;
            state_in = S_RDIFF;
         end
         S_RDIFF: begin
            r_in = {{18{py_ff[15]}}, py_ff, 16'd0}
                 - {{2{sp_ff[47]}}, sp_ff}
                 - {{6{ic_ff[31]}}, ic_ff, 12'd0};
            state_in = S_RSQ;
         end
         S_RSQ: begin
            if (issued_ff && mul_done) begin
               res_in    = res_sum[48] ? '1 : res_sum[47:0];
               issued_in = 1'b0;
               idx_in    = idx_ff + 1'b1;
               state_in  = (idx_ff + 1'b1 == count_ff) ? S_DONE : S_RREAD;
            end
         end
         S_DONE: begin
            // hand over once the output register is free, then reload
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = sing_ff;
               rsp_data_in  = {7'd0, count_ff, res_ff, ic_ff, slope_ff};
               sum_x_in     = '0;
               sum_y_in     = '0;
               sum_xx_in    = '0;
               sum_xy_in    = '0;
               count_in     = '0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xx_ff    <= '0;
         sum_xy_ff    <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_xx_ff    <= sum_xx_in;
         sum_xy_ff    <= sum_xy_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff      <= tmp_in;
      num_ff      <= num_in;
      det_ff      <= det_in;
      sing_ff     <= sing_in;
      slope_ff    <= slope_in;
      ic_ff       <= ic_in;
      res_ff      <= res_in;
      sp_ff       <= sp_in;
      py_ff       <= py_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_last_stops_load : assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !req_tready)
      else $error("loading continued after last point");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[111:0] == '0)
      else $error("singular result carries nonzero fit");

   a_one_unit : assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Least-squares line fit testbench
// Drives point sets into the fit block and compares each fit against a
// predictor with its own sums and point list. Directed sets come first, then
// random sets, under changing stall patterns on both sides.
// ----------------------------------------------------------------------------
module tb_top import llsf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic [47:0]        residual_sum;
      logic               singular;
      logic [8:0]         point_count;
   } fit_type;

   localparam logic [47:0] RES_LIMIT = 48'hFFFF_FFFF_FFFF;
   localparam int MAX_CYCLES = 3_000_000;

   // truncating divide of a wide numerator, saturated to 32 bits
   function automatic logic signed [31:0] div_sat(logic signed [127:0] num,
                                                  logic signed [63:0] den);
      logic signed [127:0] q;
      begin
         q = num / 128'(signed'(den));
         if (q > 128'sd2147483647) return 32'sh7FFF_FFFF;
         if (q < -128'sd2147483648) return 32'sh8000_0000;
         return q[31:0];
      end
   endfunction

   class fit_scoreboard;
      logic signed [23:0] sx, sy;
      logic signed [39:0] sxx, sxy;
      int                 n;
      logic signed [15:0] px[$], py[$];
      fit_type            pending[$];
      int                 errors, fits;

      function void note_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
         fit_type f;
         logic signed [63:0]  det;
         logic signed [127:0] ns, ni, r, sq;
         logic [63:0]         term;
         logic [48:0]         acc;
         if (n < MAX_POINTS) begin
            px.push_back(x);
            py.push_back(y);
            sx += 24'(x);
            sy += 24'(y);
            sxx += 40'(32'(x) * 32'(x));
            sxy += 40'(32'(x) * 32'(y));
            n++;
         end
         if (!last) return;
         det = 64'(n) * 64'(sxx) - 64'(sx) * 64'(sx);
         f.singular = (det == 0);
         f.slope = 0;
         f.intercept = 0;
         f.residual_sum = 0;
         f.point_count = n[8:0];
         if (!f.singular) begin
            ns = 128'(n) * 128'(sxy) - 128'(sx) * 128'(sy);
            ni = 128'(sxx) * 128'(sy) - 128'(sx) * 128'(sxy);
            f.slope = div_sat(ns <<< 16, det);
            f.intercept = div_sat(ni <<< 4, det);
            acc = 0;
            foreach (px[i]) begin
               r = 128'(py[i]) * 65536 - (128'(f.slope) * 128'(px[i])
                   + 128'(f.intercept) * 4096);
               sq = r * r;
               term = (sq[127:80] != 0) ? 64'(RES_LIMIT) : 64'(sq[79:32]);
               acc = acc + term;
               if (acc > RES_LIMIT) acc = RES_LIMIT;
            end
            f.residual_sum = acc[47:0];
         end
         pending.push_back(f);
         sx = 0; sy = 0; sxx = 0; sxy = 0; n = 0;
         px.delete();
         py.delete();
      endfunction

      function void check_fit(fit_type got);
         fit_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected fit: slope %h", got.slope);
            return;
         end
         e = pending.pop_front();
         fits++;
         if (got != e) begin
            errors++;
            if (errors <= 10)
               $display("fit %0d: exp s=%h i=%h r=%h sg=%b n=%0d got s=%h i=%h r=%h sg=%b n=%0d",
                  fits, e.slope, e.intercept, e.residual_sum, e.singular, e.point_count,
                  got.slope, got.intercept, got.residual_sum, got.singular, got.point_count);
         end
      endfunction
   endclass

   logic         clock = 0, reset = 1;
   logic         req_tvalid = 0, req_tlast = 0, rsp_tready = 0;
   logic [31:0]  req_tdata = 0;
   logic         req_tready, rsp_tvalid, rsp_tuser;
   logic [127:0] rsp_tdata;

   fit_scoreboard sb = new();
   int send_idle = 0, recv_idle = 0, hold_off = 0;
   int cycles = 0, points_sent = 0;

   linear_least_squares_fit u_dut (.*);

   initial forever #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random stall, long hold-off when asked
   always @(posedge clock) begin
      fit_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slope = rsp_tdata[31:0];
         got.intercept = rsp_tdata[63:32];
         got.residual_sum = rsp_tdata[111:64];
         got.point_count = rsp_tdata[120:112];
         got.singular = rsp_tuser;
         sb.check_fit(got);
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else
         rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // valid stays up after a handshake until the next request or an idle cycle
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {y, x};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_point(x, y, last);
      points_sent++;
   endtask

   task automatic send_set(int len, int kind);
      logic signed [15:0] x, y, m;
      m = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         case (kind)
            0: begin x = 16'($urandom); y = 16'($urandom); end
            1: begin x = 16'($urandom_range(0, 4095)) - 2048;
                     y = 16'((32'(x) * 32'(m)) >>> 14) + 16'($urandom_range(0, 63)); end
            default: begin x = 16'sd100; y = 16'($urandom); end   // vertical line: singular
         endcase
         send_point(x, y, i == len - 1);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int phase_sent;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: one point, two points, extremes, identical x, both signs
      send_point(16'sh7FFF, 16'sh8000, 1);
      send_point(16'sh8000, 16'sh7FFF, 0);
      send_point(16'sh7FFF, 16'sh8000, 1);
      send_point(16'sh8000, 16'sh8000, 0);
      send_point(16'sh7FFF, 16'sh7FFF, 0);
      send_point(16'sh0000, 16'sh0000, 0);
      send_point(16'shFFFF, 16'sh0001, 1);
      send_set(4, 2);
      send_point(16'sh0001, 16'sh0000, 0);
      send_point(16'sh0002, 16'sh7FFF, 1);
      send_point(16'sh0000, 16'sh8000, 0);
      send_point(16'sh0001, 16'sh7FFF, 1);
      // full store: extra points are dropped, last mark still fits
      send_idle = 0;
      for (int i = 0; i < 260; i++) send_point(16'($urandom), 16'($urandom), i == 259);
      drain();
      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 16 : (p == 1) ? 83 : 0;
         recv_idle = (p == 0) ? 83 : (p == 1) ? 16 : 0;
         phase_sent = points_sent;
         while (points_sent - phase_sent < 56) begin
            if (p == 2 && points_sent - phase_sent < 20) hold_off = 3000;
            send_set($urandom_range(1, 12), $urandom_range(0, 9) < 6 ? 1 :
                     $urandom_range(0, 4) == 0 ? 2 : 0);
         end
         drain();   // sender pauses until every fit is back
      end
      drain();
      repeat (2000) @(posedge clock);
      $display("sent %0d points, checked %0d fits incl. singular and full-store sets",
               points_sent, sb.fits);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
